>>> design/copd_pkg.sv
`timescale 1ns / 1ps

package copd_pkg;

  localparam int unsigned MAX_CIRCLES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned RADIUS_BITS     = 15;
  localparam int unsigned RSUM_BITS       = RADIUS_BITS + 1;
  localparam int unsigned RSQ_BITS        = 2 * RSUM_BITS;
  localparam int unsigned OIDX_BITS       = 6;
  localparam logic [OIDX_BITS-1:0] MAX_PAIRS = 6'd63;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } copd_state_e;

endpackage

>>> design/copd_cmp.sv
`timescale 1ns / 1ps

module copd_cmp #(
  parameter int unsigned COORD_BITS = copd_pkg::COORD_BITS_DEF,
  parameter int unsigned IDX_BITS   = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               vld_i,
  input  logic [IDX_BITS-1:0]                idx_i,
  input  logic signed [COORD_BITS-1:0]       ax_i,
  input  logic signed [COORD_BITS-1:0]       ay_i,
  input  logic [copd_pkg::RADIUS_BITS-1:0]   ar_i,
  input  logic signed [COORD_BITS-1:0]       bx_i,
  input  logic signed [COORD_BITS-1:0]       by_i,
  input  logic [copd_pkg::RADIUS_BITS-1:0]   br_i,
  output logic                               vld_o,
  output logic [IDX_BITS-1:0]                idx_o,
  output logic                               hit_o,
  output logic                               busy_o
);

  localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
  localparam int unsigned CMP_BITS =
    (SQ_BITS + 1 > copd_pkg::RSQ_BITS) ? SQ_BITS + 1 : copd_pkg::RSQ_BITS;

  logic signed [COORD_BITS:0]          dxs, dys;
  logic [COORD_BITS-1:0]               dx_d, dy_d;
  logic [COORD_BITS-1:0]               dx_q, dy_q;
  logic [copd_pkg::RSUM_BITS-1:0]      rs_q;
  logic                                va_q, vb_q;
  logic [IDX_BITS-1:0]                 ia_q, ib_q;
  logic [SQ_BITS-1:0]                  sx_q, sy_q;
  logic [copd_pkg::RSQ_BITS-1:0]       rs2_q;
  logic [SQ_BITS:0]                    d2;

  // absolute differences; magnitude always fits in COORD_BITS
  always_comb begin
    dxs  = {ax_i[COORD_BITS-1], ax_i} - {bx_i[COORD_BITS-1], bx_i};
    dys  = {ay_i[COORD_BITS-1], ay_i} - {by_i[COORD_BITS-1], by_i};
    dx_d = dxs[COORD_BITS] ? COORD_BITS'(-dxs) : dxs[COORD_BITS-1:0];
    dy_d = dys[COORD_BITS] ? COORD_BITS'(-dys) : dys[COORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= vld_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      rs_q  <= {1'b0, ar_i} + {1'b0, br_i};
      ia_q  <= idx_i;
      sx_q  <= SQ_BITS'(dx_q) * SQ_BITS'(dx_q);
      sy_q  <= SQ_BITS'(dy_q) * SQ_BITS'(dy_q);
      rs2_q <= copd_pkg::RSQ_BITS'(rs_q) * copd_pkg::RSQ_BITS'(rs_q);
      ib_q  <= ia_q;
    end
  end

  assign d2     = {1'b0, sx_q} + {1'b0, sy_q};
  assign hit_o  = CMP_BITS'(d2) <= CMP_BITS'(rs2_q);
  assign vld_o  = vb_q;
  assign idx_o  = ib_q;
  assign busy_o = va_q | vb_q;

endmodule

>>> design/circle_overlap_pair_detector_top.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid_i/in_stall_o  x_pos_i, y_pos_i, radius_i, first_of_set_i
// out      out_valid_o/out_stall_i pair_valid_o, earlier_index_o, new_index_o,
//                                 overlap_count_o, set_full_o, last_o
// While a circle with index n >= 1 is processed the input stalls: n stored circles
// are read, one per cycle unless the output stalls, then the read register and two
// compare stages drain and the status item is loaded. Index 0 or dropped: no reads.
// Reset clears the circle count; memory contents need no clearing.
// A stall on the output freezes the read and compare pipeline in place.
module circle_overlap_pair_detector_top #(
  parameter int unsigned MAX_CIRCLES = copd_pkg::MAX_CIRCLES_DEF,
  parameter int unsigned COORD_BITS  = copd_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      x_pos_i,
  input  logic signed [COORD_BITS-1:0]      y_pos_i,
  input  logic [copd_pkg::RADIUS_BITS-1:0]  radius_i,
  input  logic                              first_of_set_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              pair_valid_o,
  output logic [copd_pkg::OIDX_BITS-1:0]    earlier_index_o,
  output logic [copd_pkg::OIDX_BITS-1:0]    new_index_o,
  output logic [copd_pkg::OIDX_BITS-1:0]    overlap_count_o,
  output logic                              set_full_o,
  output logic                              last_o
);

  localparam int unsigned IW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int unsigned CW = $clog2(MAX_CIRCLES + 1);
  localparam int unsigned EW = 2 * COORD_BITS + copd_pkg::RADIUS_BITS;
  localparam int unsigned OW = copd_pkg::OIDX_BITS;

  logic [EW-1:0] mem [MAX_CIRCLES];

  copd_pkg::copd_state_e state_q, state_d;

  logic [CW-1:0]  count_q, count_d, base;
  logic           full, in_acc, adv, issue, we;
  logic [IW-1:0]  idx_q, idx_d, lim_q, lim_d, j_q, j_d;
  logic           full_q, full_d;
  logic signed [COORD_BITS-1:0]     nx_q, ny_q;
  logic [copd_pkg::RADIUS_BITS-1:0] nr_q;
  logic           v1_q, v1_d;
  logic [IW-1:0]  j1_q;
  logic [EW-1:0]  rd_q;
  logic [OW-1:0]  found_q, found_d;

  logic           cmp_vld, cmp_hit, cmp_busy;
  logic [IW-1:0]  cmp_idx;
  logic [IW+OW-1:0] cmp_idx_ext, idx_ext;

  logic           out_vld_q, out_vld_d, load_pair, load_stat;
  logic           pv_q, full_o_q;
  logic [OW-1:0]  ei_q, ni_q, cnt_q;

  assign in_stall_o = (state_q != copd_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !out_vld_q || !out_stall_i;

  assign base = first_of_set_i ? '0 : count_q;
  assign full = (base == CW'(MAX_CIRCLES));
  assign we   = in_acc && !full;

  assign cmp_idx_ext = {{OW{1'b0}}, cmp_idx};
  assign idx_ext     = {{OW{1'b0}}, idx_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    lim_d     = lim_q;
    full_d    = full_q;
    j_d       = j_q;
    found_d   = found_q;
    v1_d      = v1_q;
    out_vld_d = out_vld_q;
    issue     = 1'b0;
    load_pair = 1'b0;
    load_stat = 1'b0;
    case (state_q)
      copd_pkg::ST_IDLE: begin
        if (adv) begin
          v1_d = 1'b0;
        end
        if (in_acc) begin
          idx_d   = full ? '0 : base[IW-1:0];
          lim_d   = full ? '0 : base[IW-1:0];
          full_d  = full;
          j_d     = '0;
          found_d = '0;
          if (!full) begin
            count_d = base + CW'(1);
          end
          state_d = copd_pkg::ST_SCAN;
        end
      end
      copd_pkg::ST_SCAN: begin
        if (adv) begin
          issue = (j_q != lim_q);
          v1_d  = issue;
          if (issue) begin
            j_d = j_q + IW'(1);
          end
          if (cmp_vld && cmp_hit && found_q != copd_pkg::MAX_PAIRS) begin
            load_pair = 1'b1;
            found_d   = found_q + OW'(1);
          end
          // all reads issued and the pipeline empty: close the run
          if (!issue && !v1_q && !cmp_busy) begin
            load_stat = 1'b1;
            state_d   = copd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = copd_pkg::ST_IDLE;
      end
    endcase
    if (adv) begin
      out_vld_d = load_pair || load_stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= copd_pkg::ST_IDLE;
      count_q   <= '0;
      v1_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      v1_q      <= v1_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lim_q   <= lim_d;
    full_q  <= full_d;
    j_q     <= j_d;
    found_q <= found_d;
    if (in_acc) begin
      nx_q <= x_pos_i;
      ny_q <= y_pos_i;
      nr_q <= radius_i;
    end
    if (issue) begin
      j1_q <= j_q;
    end
    if (load_pair) begin
      pv_q     <= 1'b1;
      ei_q     <= cmp_idx_ext[OW-1:0];
      ni_q     <= idx_ext[OW-1:0];
      cnt_q    <= '0;
      full_o_q <= 1'b0;
    end else if (load_stat) begin
      pv_q     <= 1'b0;
      ei_q     <= '0;
      ni_q     <= idx_ext[OW-1:0];
      cnt_q    <= found_d;
      full_o_q <= full_q;
    end
  end

  // circle memory: the new circle goes to its own slot, reads only cover lower slots
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[base[IW-1:0]] <= {x_pos_i, y_pos_i, radius_i};
    end
    if (issue) begin
      rd_q <= mem[j_q];
    end
  end

  copd_cmp #(
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (IW)
  ) u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (v1_q),
    .idx_i  (j1_q),
    .ax_i   (rd_q[EW-1 -: COORD_BITS]),
    .ay_i   (rd_q[copd_pkg::RADIUS_BITS +: COORD_BITS]),
    .ar_i   (rd_q[copd_pkg::RADIUS_BITS-1:0]),
    .bx_i   (nx_q),
    .by_i   (ny_q),
    .br_i   (nr_q),
    .vld_o  (cmp_vld),
    .idx_o  (cmp_idx),
    .hit_o  (cmp_hit),
    .busy_o (cmp_busy)
  );

  assign out_valid_o     = out_vld_q;
  assign pair_valid_o    = pv_q;
  assign earlier_index_o = ei_q;
  assign new_index_o     = ni_q;
  assign overlap_count_o = cnt_q;
  assign set_full_o      = full_o_q;
  assign last_o          = !pv_q;

endmodule

>>> sim/circle_overlap_pair_detector_top_tb.sv
`timescale 1ns / 1ps

module circle_overlap_pair_detector_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  typedef struct {
    logic                           pair_valid;
    logic [copd_pkg::OIDX_BITS-1:0] earlier_index;
    logic [copd_pkg::OIDX_BITS-1:0] new_index;
    logic [copd_pkg::OIDX_BITS-1:0] overlap_count;
    logic                           set_full;
    logic                           last;
  } overlap_result_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic signed [15:0]               x_pos_i;
  logic signed [15:0]               y_pos_i;
  logic [copd_pkg::RADIUS_BITS-1:0] radius_i;
  logic                             first_of_set_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic                             pair_valid_o;
  logic [copd_pkg::OIDX_BITS-1:0]   earlier_index_o;
  logic [copd_pkg::OIDX_BITS-1:0]   new_index_o;
  logic [copd_pkg::OIDX_BITS-1:0]   overlap_count_o;
  logic                             set_full_o;
  logic                             last_o;

  // Predicted circle set
  logic signed [15:0]               set_x [copd_pkg::MAX_CIRCLES_DEF];
  logic signed [15:0]               set_y [copd_pkg::MAX_CIRCLES_DEF];
  logic [copd_pkg::RADIUS_BITS-1:0] set_r [copd_pkg::MAX_CIRCLES_DEF];
  int unsigned                      set_count;
  bit                               circle_dropped;

  overlap_result_t                  pending_results[$];
  int unsigned                      error_count;
  int unsigned                      stuck_cycles;
  int unsigned                      send_idle_pct;
  int unsigned                      recv_idle_pct;

  circle_overlap_pair_detector_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .x_pos_i         (x_pos_i),
    .y_pos_i         (y_pos_i),
    .radius_i        (radius_i),
    .first_of_set_i  (first_of_set_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pair_valid_o    (pair_valid_o),
    .earlier_index_o (earlier_index_o),
    .new_index_o     (new_index_o),
    .overlap_count_o (overlap_count_o),
    .set_full_o      (set_full_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Exact integer test, no square root: d^2 <= (r1 + r2)^2
  function automatic bit circles_touch(input logic signed [15:0] ax, ay,
                                       input logic [copd_pkg::RADIUS_BITS-1:0] ar,
                                       input logic signed [15:0] bx, by,
                                       input logic [copd_pkg::RADIUS_BITS-1:0] br);
    longint dx;
    longint dy;
    longint rsum;
    dx   = longint'(ax) - longint'(bx);
    dy   = longint'(ay) - longint'(by);
    rsum = longint'(ar) + longint'(br);
    return (dx * dx + dy * dy) <= (rsum * rsum);
  endfunction

  task automatic predict_overlaps(input logic signed [15:0] x, y,
                                  input logic [copd_pkg::RADIUS_BITS-1:0] r,
                                  input logic first);
    overlap_result_t res;
    int unsigned found;
    found = 0;
    if (first) set_count = 0;
    circle_dropped = (set_count >= copd_pkg::MAX_CIRCLES_DEF);
    if (circle_dropped) begin
      res = '{1'b0, '0, '0, '0, 1'b1, 1'b1};
      pending_results = {pending_results, res};
    end else begin
      for (int j = 0; j < set_count; j++) begin
        if (found < copd_pkg::MAX_PAIRS &&
            circles_touch(set_x[j], set_y[j], set_r[j], x, y, r)) begin
          res = '{1'b1, copd_pkg::OIDX_BITS'(j), copd_pkg::OIDX_BITS'(set_count), '0,
                  1'b0, 1'b0};
          pending_results = {pending_results, res};
          found++;
        end
      end
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_r[set_count] = r;
      res = '{1'b0, '0, copd_pkg::OIDX_BITS'(set_count), copd_pkg::OIDX_BITS'(found),
              1'b0, 1'b1};
      pending_results = {pending_results, res};
      set_count++;
    end
  endtask

  task automatic send_circle(input logic signed [15:0] x, y,
                             input logic [copd_pkg::RADIUS_BITS-1:0] r,
                             input logic first);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    x_pos_i        <= x;
    y_pos_i        <= y;
    radius_i       <= r;
    first_of_set_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    predict_overlaps(x, y, r, first);
  endtask

  function automatic void check_field(input string name, input int unsigned expected,
                                      input int unsigned actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endfunction

  task automatic check_result();
    overlap_result_t res;
    if (pending_results.size() == 0) begin
      $error("unexpected result item: pair_valid %0d new_index %0d", pair_valid_o,
             new_index_o);
      error_count++;
    end else begin
      res = pending_results.pop_front();
      check_field("pair_valid", res.pair_valid, pair_valid_o);
      check_field("earlier_index", res.earlier_index, earlier_index_o);
      check_field("new_index", res.new_index, new_index_o);
      check_field("overlap_count", res.overlap_count, overlap_count_o);
      check_field("set_full", res.set_full, set_full_o);
      check_field("last", res.last, last_o);
    end
  endtask

  // Check results and watch for a hung handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("circle_overlap_pair_detector_top_tb NOT OK");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic test_directed();
    // Zero radii at the same centre, corner extremes
    send_circle(-16'sd32768, -16'sd32768, 15'd0, 1'b1);
    send_circle(-16'sd32768, -16'sd32768, 15'd0, 1'b0);
    send_circle(16'sd32767, 16'sd32767, 15'd32767, 1'b0);
    send_circle(-16'sd32768, -16'sd32768, 15'd32767, 1'b0);
    send_circle(16'sd32767, -16'sd32768, 15'd32767, 1'b0);
    // Exactly touching at distance 80, then one unit short
    send_circle(16'sd0, 16'sd0, 15'd16, 1'b1);
    send_circle(16'sd48, 16'sd64, 15'd64, 1'b0);
    send_circle(16'sd0, -16'sd80, 15'd63, 1'b0);
    send_circle(-16'sd1, 16'sd0, 15'd1, 1'b0);
    send_circle(16'sd1, -16'sd1, 15'd0, 1'b0);
    // New set in the middle of a set restarts at index 0
    send_circle(16'sh5555, 16'shAAAA, 15'h2AAA, 1'b1);
    send_circle(16'shAAAA, 16'sh5555, 15'h5555, 1'b0);
    send_circle(-16'sd32768, 16'sd32767, 15'h4000, 1'b0);
    send_circle(16'sd0, 16'sd0, 15'h7FFF, 1'b0);
    send_circle(16'sd100, 16'sd100, 15'd0, 1'b1);
    send_circle(16'sd100, 16'sd101, 15'd0, 1'b0);
    send_circle(16'sd100, 16'sd100, 15'd1, 1'b0);
  endtask

  task automatic test_store_full();
    // Fill the set with mutually overlapping circles, then overflow it
    send_circle(16'sd0, 16'sd0, 15'h100, 1'b1);
    for (int i = 1; i < copd_pkg::MAX_CIRCLES_DEF; i++) begin
      send_circle(16'($urandom_range(32) - 16), 16'($urandom_range(32) - 16), 15'h100, 1'b0);
    end
    send_circle(16'sd0, 16'sd0, 15'h100, 1'b0);
    send_circle(16'sd32767, -16'sd32768, 15'h7FFF, 1'b0);
    // First of set is never dropped
    send_circle(16'sd5, 16'sd5, 15'd3, 1'b1);
  endtask

  task automatic test_random_sets(input int unsigned n_items);
    int unsigned sent;
    int unsigned set_len;
    int          spread;
    int          cx;
    int          cy;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        // Noise: any field value, set boundary at random
        send_circle(16'($urandom), 16'($urandom), 15'($urandom), 1'($urandom_range(1)));
        if (!circle_dropped) sent++;
      end else begin
        set_len = ($urandom_range(99) < 6) ? $urandom_range(40, 72) : $urandom_range(1, 12);
        spread  = 1 << $urandom_range(2, 12);
        cx      = $urandom_range(65535) - 32768;
        cy      = $urandom_range(65535) - 32768;
        for (int i = 0; i < set_len; i++) begin
          send_circle(16'(cx + $urandom_range(2 * spread) - spread),
                      16'(cy + $urandom_range(2 * spread) - spread),
                      15'($urandom_range(spread)), i == 0);
          if (!circle_dropped) sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    x_pos_i        = '0;
    y_pos_i        = '0;
    radius_i       = '0;
    first_of_set_i = 1'b0;
    out_stall_i    = 1'b0;
    set_count      = 0;
    circle_dropped = 1'b0;
    error_count    = 0;
    stuck_cycles   = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 71;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_store_full();
    test_random_sets(46);
    send_idle_pct = 71;
    recv_idle_pct = 17;
    test_random_sets(46);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(46);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("circle_overlap_pair_detector_top_tb OK");
    end else begin
      $display("circle_overlap_pair_detector_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
design/copd_pkg.sv
design/copd_cmp.sv
design/circle_overlap_pair_detector_top.sv
sim/circle_overlap_pair_detector_top_tb.sv
